>>> hw/rtl/rtcc_pkg.sv
package rtcc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned OPC_W  = 6;
	localparam int unsigned REG_W  = 5;

	// APB register map
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic        REG_EXPECTED_SUM = 1'b0;   // selected by paddr[2]

	localparam logic [WORD_W-1:0] EXPECTED_SUM_RESET = 32'h0024_99BF;

	// MIPS opcodes of interest
	localparam logic [OPC_W-1:0] OP_JAL   = 6'h03;
	localparam logic [OPC_W-1:0] OP_ADDIU = 6'h09;
	localparam logic [OPC_W-1:0] OP_LUI   = 6'h0F;
	localparam logic [OPC_W-1:0] OP_LW    = 6'h23;

	localparam logic [HALF_W-1:0] JAL_HI_MASK = 16'hFC00;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t instruction_word;
		logic  start_of_run;
		logic  end_of_run;
	} item_t;

	typedef struct packed {
		word_t running_sum;
		logic  sum_matches;
		logic  is_final;
	} result_t;

	function automatic logic [OPC_W-1:0] opc_of(input word_t w);
		return w[31:26];
	endfunction

	function automatic logic [REG_W-1:0] rs_of(input word_t w);
		return w[25:21];
	endfunction

	function automatic logic [REG_W-1:0] rt_of(input word_t w);
		return w[20:16];
	endfunction

endpackage

>>> hw/rtl/rtcc_if.sv
interface rtcc_in_if
	import rtcc_pkg::*;
();

	logic  valid;
	logic  ready;
	word_t instruction_word;
	logic  start_of_run;
	logic  end_of_run;

	modport source (output valid, output instruction_word, output start_of_run,
		output end_of_run, input ready);
	modport sink (input valid, input instruction_word, input start_of_run,
		input end_of_run, output ready);
endinterface

interface rtcc_out_if
	import rtcc_pkg::*;
();

	logic  valid;
	logic  ready;
	word_t running_sum;
	logic  sum_matches;
	logic  is_final;

	modport source (output valid, output running_sum, output sum_matches,
		output is_final, input ready);
	modport sink (input valid, input running_sum, input sum_matches,
		input is_final, output ready);
endinterface

>>> hw/rtl/rtcc_delta.sv
module rtcc_delta
	import rtcc_pkg::*;
(
	input  word_t word,
	input  word_t prev,
	output word_t delta
);

	logic [HALF_W-1:0] lo;
	logic [HALF_W-1:0] hi;
	logic [HALF_W-1:0] prev_lo;
	logic              lui_pair;
	logic              is_jal;
	word_t             add_part;
	word_t             sub_part;

	assign lo      = word[15:0];
	assign hi      = word[31:16];
	assign prev_lo = prev[15:0];

	// a LUI feeding an ADDIU or LW on the same register is a relocated address
	assign lui_pair = (opc_of(prev) == OP_LUI)
		&& ((opc_of(word) == OP_ADDIU) || (opc_of(word) == OP_LW))
		&& (rs_of(word) == rt_of(prev))
		&& (rs_of(word) == rt_of(word));

	assign is_jal = (opc_of(word) == OP_JAL);

	assign add_part = {16'd0, lo} + {16'd0, hi};

	always_comb begin
		sub_part = '0;
		if (lui_pair) begin
			sub_part = {16'd0, lo} + {16'd0, prev_lo};
		end else if (is_jal) begin
			sub_part = {16'd0, lo} + {16'd0, hi & JAL_HI_MASK};
		end
	end

	assign delta = add_part - sub_part;

endmodule

>>> hw/rtl/relocation_tolerant_code_checksum_unit.sv
// Relocation-tolerant checksum over a stream of MIPS instruction words. One word
// is taken per cycle while the skid entry is empty; each result is registered,
// and the accumulator update (word contribution, add, compare against
// expected_sum) is done in one pass of combinational logic. A two-entry output
// buffer lets one more input transfer be taken while the result side is
// stalled. expected_sum is written over APB at byte address 0 and should only
// be changed while no results are outstanding.
module relocation_tolerant_code_checksum_unit
	import rtcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rtcc_in_if.sink               item_in,
	rtcc_out_if.source            result_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	word_t   expected_q;
	word_t   acc_q;
	word_t   prev_q;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	logic    accept;
	logic    pop;
	word_t   base;
	word_t   prev_sel;
	word_t   delta;
	word_t   new_sum;
	result_t new_res;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EXPECTED_SUM) ? expected_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= EXPECTED_SUM_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == REG_EXPECTED_SUM)) begin
			expected_q <= pwdata;
		end
	end

	// datapath
	assign accept   = item_in.valid && item_in.ready;
	assign pop      = out_valid_q && result_out.ready;
	assign base     = item_in.start_of_run ? '0 : acc_q;
	assign prev_sel = item_in.start_of_run ? '0 : prev_q;

	rtcc_delta u_delta (
		.word  (item_in.instruction_word),
		.prev  (prev_sel),
		.delta (delta)
	);

	assign new_sum = base + delta;

	assign new_res.running_sum = new_sum;
	assign new_res.sum_matches = (new_sum == expected_q);
	assign new_res.is_final    = item_in.end_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			prev_q <= '0;
		end else if (accept) begin
			acc_q  <= new_sum;
			prev_q <= item_in.instruction_word;
		end
	end

	// output register plus skid entry
	assign item_in.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= accept || skid_valid_q || (out_valid_q && !pop);
			skid_valid_q <= pop ? 1'b0 : (skid_valid_q || (accept && out_valid_q));
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
		if (accept) begin
			if (!out_valid_q || (pop && !skid_valid_q)) begin
				out_q <= new_res;
			end else begin
				skid_q <= new_res;
			end
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.running_sum = out_q.running_sum;
	assign result_out.sum_matches = out_q.sum_matches;
	assign result_out.is_final    = out_q.is_final;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item_in.start_of_run) |=> (acc_q == $past(delta)))
		else $error("start of run did not restart the sum");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (prev_q == $past(item_in.instruction_word)))
		else $error("previous word not captured on transfer");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_out.valid)
		else $error("transfer taken without a result pending");

endmodule

>>> tb/relocation_tolerant_code_checksum_unit_tb.sv
`timescale 1ns / 100ps

module relocation_tolerant_code_checksum_unit_tb;
	import rtcc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned WORD_TARGET = 440;
	localparam logic [APB_ADDR_W-1:0] ADDR_EXPECTED = {REG_EXPECTED_SUM, 2'b00};

	logic clk = 1'b0;
	logic arst_n;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	rtcc_in_if in_bus ();
	rtcc_out_if out_bus ();

	relocation_tolerant_code_checksum_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_bus),
		.result_out (out_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// checksum model state
	word_t run_sum = '0;
	word_t prior_word = '0;
	word_t cfg_expected = EXPECTED_SUM_RESET;

	item_t words_to_send[$];
	item_t region_log[$];
	result_t sums_due[$];

	int errors = 0;
	int words_queued = 0;
	int hold_req = 0;
	int unsigned cycle_cnt = 0;

	function automatic result_t fold_word(input word_t w, input logic start, input logic last);
		word_t s;
		word_t p;
		result_t r;
		if (start) begin
			run_sum = '0;
			prior_word = '0;
		end
		s = run_sum;
		p = prior_word;
		s = s + w[15:0] + w[31:16];
		// LUI paired with ADDIU/LW on the same register: drop both immediates
		if (p[31:26] == OP_LUI && (w[31:26] == OP_ADDIU || w[31:26] == OP_LW) &&
				w[25:21] == p[20:16] && w[25:21] == w[20:16]) begin
			s = s - w[15:0];
			s = s - p[15:0];
		end
		if (w[31:26] == OP_JAL)
			s = s - (w[15:0] + (w[31:16] & JAL_HI_MASK));
		run_sum = s;
		prior_word = w;
		r.running_sum = s;
		r.sum_matches = (s == cfg_expected);
		r.is_final = last;
		return r;
	endfunction

	function automatic void put(input word_t w, input logic st, input logic en);
		item_t it;
		it.instruction_word = w;
		it.start_of_run = st;
		it.end_of_run = en;
		words_to_send.push_back(it);
		region_log.push_back(it);
		words_queued++;
	endfunction

	function automatic word_t rand_lui(input logic [REG_W-1:0] r);
		return {OP_LUI, REG_W'($urandom), r, HALF_W'($urandom)};
	endfunction

	// well-formed region: start on the first word, end on the last
	function automatic void add_region(input int len);
		int i;
		int k;
		logic [REG_W-1:0] r;
		logic [REG_W-1:0] rs2;
		logic [REG_W-1:0] rt2;
		logic [OPC_W-1:0] op2;
		word_t w;
		region_log.delete();
		i = 0;
		while (i < len) begin
			k = $urandom_range(0, 9);
			if (k < 4 && i + 1 < len) begin
				r = REG_W'($urandom);
				put(rand_lui(r), i == 0, 1'b0);
				i++;
				op2 = $urandom_range(0, 1) ? OP_ADDIU : OP_LW;
				rs2 = r;
				rt2 = r;
				case ($urandom_range(0, 5))
					0: rt2 = r ^ REG_W'($urandom_range(1, 31));
					1: rs2 = r ^ REG_W'($urandom_range(1, 31));
					default: ;
				endcase
				w = {op2, rs2, rt2, HALF_W'($urandom)};
			end else if (k < 6) begin
				w = {OP_JAL, 26'($urandom)};
			end else begin
				w = $urandom;
			end
			put(w, i == 0, i == len - 1);
			i++;
		end
	endfunction

	// stray flags anywhere, words after the end that keep accumulating
	function automatic void add_noise(input int len);
		int i;
		word_t w;
		for (i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: w = rand_lui(REG_W'($urandom));
				1: w = {($urandom_range(0, 1) ? OP_ADDIU : OP_LW), 26'($urandom)};
				default: w = $urandom;
			endcase
			put(w, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		end
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	logic offer;
	item_t nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			in_bus.instruction_word <= '0;
			in_bus.start_of_run <= 1'b0;
			in_bus.end_of_run <= 1'b0;
		end else begin
			if (in_bus.valid && in_bus.ready)
				sums_due.push_back(fold_word(in_bus.instruction_word, in_bus.start_of_run,
					in_bus.end_of_run));
			offer = in_bus.valid && !in_bus.ready;
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (words_to_send.size() > 0) begin
					nxt = words_to_send.pop_front();
					offer = 1'b1;
					in_bus.instruction_word <= nxt.instruction_word;
					in_bus.start_of_run <= nxt.start_of_run;
					in_bus.end_of_run <= nxt.end_of_run;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_bus.valid <= offer;
		end
	end

	// receiver: stall pattern in modes, plus a long hold on request
	int hold_seen = 0;
	int hold_left = 0;
	int pat_mode = 0;
	int pat_left = 0;
	logic rdy;
	result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: result with none due: sum %h match %b final %b", $time,
						out_bus.running_sum, out_bus.sum_matches, out_bus.is_final);
					errors++;
				end else begin
					want = sums_due.pop_front();
					if (out_bus.running_sum !== want.running_sum) begin
						$display("%0t: running_sum expected %h actual %h", $time,
							want.running_sum, out_bus.running_sum);
						errors++;
					end
					if (out_bus.sum_matches !== want.sum_matches) begin
						$display("%0t: sum_matches expected %b actual %b", $time,
							want.sum_matches, out_bus.sum_matches);
						errors++;
					end
					if (out_bus.is_final !== want.is_final) begin
						$display("%0t: is_final expected %b actual %b", $time,
							want.is_final, out_bus.is_final);
						errors++;
					end
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(16, 128);
				end
				pat_left--;
				case (pat_mode)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = (pat_left % 5 != 0);
				endcase
			end
			out_bus.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_check(input word_t v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_EXPECTED;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v) begin
			$display("%0t: expected_sum readback expected %h actual %h", $time, v, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_expected(input word_t v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_EXPECTED;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_expected = v;
		reg_check(v);
		@(negedge clk);
	endtask

	// wait for every transfer to land, then let the pipeline empty
	task automatic settle;
		while (words_to_send.size() != 0 || in_bus.valid || sums_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	int phase_no;
	int n_chunks;
	int j;
	item_t replay_q[$];

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		reg_check(EXPECTED_SUM_RESET);
		@(negedge clk);

		region_log.delete();
		put(32'h0000_0000, 1'b1, 1'b0);
		put(32'hFFFF_FFFF, 1'b0, 1'b0);
		put(32'h3C01_6C07, 1'b0, 1'b0);
		put(32'h2421_1234, 1'b0, 1'b0);
		put(32'h3C03_ABCD, 1'b0, 1'b0);
		put(32'h8C63_FFFF, 1'b0, 1'b0);
		// rt differs from the LUI register, then rs differs
		put(32'h3C05_1111, 1'b0, 1'b0);
		put(32'h24A6_0001, 1'b0, 1'b0);
		put(32'h3C05_2222, 1'b0, 1'b0);
		put(32'h24C6_0002, 1'b0, 1'b0);
		put(32'h0FEF_EFEF, 1'b0, 1'b0);
		put(32'h0FFF_FFFF, 1'b0, 1'b1);
		// keeps accumulating past the end
		put(32'h0C00_0000, 1'b0, 1'b0);
		// start wipes the LUI, so no pair on the next word
		put(32'h3C01_6C07, 1'b0, 1'b0);
		put(32'h2421_1234, 1'b1, 1'b0);
		put(32'h3C1F_0000, 1'b0, 1'b0);
		put(32'h8FFF_0000, 1'b0, 1'b0);
		put(32'h3C00_FFFF, 1'b0, 1'b0);
		put(32'h2400_0000, 1'b0, 1'b0);
		put(32'hFFFF_FFFF, 1'b1, 1'b1);
		put(32'h0000_0000, 1'b0, 1'b1);
		settle();

		// replay with the final sum as the target, so the last word matches
		replay_q = region_log;
		set_expected(run_sum);
		foreach (replay_q[i])
			words_to_send.push_back(replay_q[i]);
		settle();

		set_expected('0);
		region_log.delete();
		put(32'h0000_0000, 1'b1, 1'b1);
		put(32'h0000_0000, 1'b0, 1'b1);
		settle();

		set_expected('1);
		phase_no = 0;
		while (words_queued < WORD_TARGET) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					replay_q = region_log;
					set_expected(run_sum);
					foreach (replay_q[i])
						words_to_send.push_back(replay_q[i]);
				end
				2: set_expected($urandom);
				3: set_expected('1);
				4: set_expected(EXPECTED_SUM_RESET);
				default: set_expected('0);
			endcase
			// hold the receiver off while a full phase is offered
			if (phase_no == 1)
				hold_req++;
			n_chunks = $urandom_range(1, 5);
			for (j = 0; j < n_chunks; j++) begin
				if ($urandom_range(0, 4) == 0)
					add_noise($urandom_range(1, 8));
				else
					add_region(($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) :
						$urandom_range(1, 16));
			end
			add_region($urandom_range(1, 12));
			settle();
			phase_no++;
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
